[rtl/core/tcprx_pkg.sv]
`timescale 1ns / 1ps

package tcprx_pkg;

  // Connection state codes, shared by the step logic and the result beat
  localparam logic [3:0] ST_CLOSED     = 4'd0;
  localparam logic [3:0] ST_LISTEN     = 4'd1;
  localparam logic [3:0] ST_SYN_RCVD   = 4'd2;
  localparam logic [3:0] ST_SYN_SENT   = 4'd3;
  localparam logic [3:0] ST_ESTAB      = 4'd4;
  localparam logic [3:0] ST_PEER_FIN   = 4'd5;
  localparam logic [3:0] ST_LAST_ACK   = 4'd6;
  localparam logic [3:0] ST_FIN_WAIT1  = 4'd7;
  localparam logic [3:0] ST_FIN_WAIT2  = 4'd8;
  localparam logic [3:0] ST_CLOSING    = 4'd9;
  localparam logic [3:0] ST_LINGER     = 4'd10;

  // Item kinds
  localparam logic ACT_SEGMENT = 1'b0;
  localparam logic ACT_FORCE   = 1'b1;

  // Flag bit positions
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;

  // Reply codes
  localparam logic [1:0] REPLY_NONE   = 2'd0;
  localparam logic [1:0] REPLY_ACK    = 2'd1;
  localparam logic [1:0] REPLY_SYNACK = 2'd2;
  localparam logic [1:0] REPLY_RESET  = 2'd3;

  // Wakeup bits
  localparam logic [3:0] WAKE_SEND    = 4'b0001;
  localparam logic [3:0] WAKE_CONNECT = 4'b0010;
  localparam logic [3:0] WAKE_ACCEPT  = 4'b0100;
  localparam logic [3:0] WAKE_RECV    = 4'b1000;

  typedef struct packed {
    logic        action;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_seq_end;
    logic [31:0] seg_ack;
    logic [15:0] peer_window;
    logic [15:0] payload_len;
    logic [31:0] send_next;
    logic [15:0] local_window;
    logic [3:0]  forced_state;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  next_state;
    logic [1:0]  reply_kind;
    logic        spawn_child;
    logic [31:0] child_expect;
    logic        remove_lookup;
    logic        release_port;
    logic [3:0]  wake_events;
    logic        start_timewait;
    logic [15:0] deliver_len;
    logic        dropped;
    logic [15:0] send_window;
  } out_beat_t;

  // Stored connection context seen by the step logic
  typedef struct packed {
    logic [3:0]  conn_state;
    logic [15:0] window_to_peer;
  } ctx_t;

  // Context update produced by one step
  typedef struct packed {
    logic [3:0]  conn_state;
    logic [15:0] window_to_peer;
    logic        load_seq;
  } upd_t;

  // a is before b in wrapping 32-bit sequence space
  function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

[rtl/core/tcprx_step.sv]
`timescale 1ns / 1ps

module tcprx_step (
  input  tcprx_pkg::in_beat_t  item,
  input  logic [31:0]          rcv_end,
  input  tcprx_pkg::ctx_t      ctx,
  output tcprx_pkg::out_beat_t res,
  output tcprx_pkg::upd_t      upd
);

  logic        drop;
  logic        bad;
  logic        win_ok;
  logic        ack_match;
  logic [3:0]  nstate;
  logic [15:0] nwin;
  logic [3:0]  win_wake;

  // Ack is already recorded as oldest unacked in the states that update
  // the window, so only the upper bound against send_next remains.
  assign win_ok = (item.seg_ack == item.send_next) ||
                  tcprx_pkg::seq_before(item.seg_ack, item.send_next);
  assign win_wake = (win_ok && (ctx.window_to_peer == '0)) ? tcprx_pkg::WAKE_SEND : 4'b0000;
  assign ack_match = (item.seg_ack == item.send_next) && item.seg_flags[tcprx_pkg::FLAG_ACK];

  always_comb begin
    res          = '0;
    drop         = 1'b0;
    bad          = 1'b0;
    nstate       = ctx.conn_state;
    nwin         = ctx.window_to_peer;
    upd.load_seq = 1'b0;

    if (item.action == tcprx_pkg::ACT_FORCE) begin
      nstate = (item.forced_state > tcprx_pkg::ST_LINGER) ? tcprx_pkg::ST_CLOSED
                                                          : item.forced_state;
    end else if (item.seg_flags[tcprx_pkg::FLAG_RST]) begin
      nstate            = tcprx_pkg::ST_CLOSED;
      res.remove_lookup = 1'b1;
    end else begin
      // synchronized states record ack/seq_end; all but syn-sent check the receive window
      if ((ctx.conn_state != tcprx_pkg::ST_CLOSED) &&
          (ctx.conn_state != tcprx_pkg::ST_LISTEN)) begin
        upd.load_seq = 1'b1;
        if ((ctx.conn_state != tcprx_pkg::ST_SYN_SENT) &&
            !tcprx_pkg::seq_before(item.seg_seq, rcv_end)) begin
          drop = 1'b1;
        end
      end

      if (!drop) begin
        unique case (ctx.conn_state)
          tcprx_pkg::ST_LISTEN: begin
            if (item.seg_flags[tcprx_pkg::FLAG_SYN]) begin
              res.spawn_child  = 1'b1;
              res.child_expect = item.seg_seq_end;
              res.reply_kind   = tcprx_pkg::REPLY_SYNACK;
            end else begin
              bad = 1'b1;
            end
          end
          tcprx_pkg::ST_SYN_RCVD: begin
            if (item.seg_flags[tcprx_pkg::FLAG_ACK]) begin
              nstate          = tcprx_pkg::ST_ESTAB;
              nwin            = win_ok ? item.peer_window : ctx.window_to_peer;
              res.wake_events = win_wake | tcprx_pkg::WAKE_ACCEPT;
            end else begin
              bad = 1'b1;
            end
          end
          tcprx_pkg::ST_SYN_SENT: begin
            if (item.seg_flags[tcprx_pkg::FLAG_ACK] || item.seg_flags[tcprx_pkg::FLAG_SYN]) begin
              nstate          = tcprx_pkg::ST_ESTAB;
              nwin            = win_ok ? item.peer_window : ctx.window_to_peer;
              res.wake_events = win_wake | tcprx_pkg::WAKE_CONNECT;
              res.reply_kind  = tcprx_pkg::REPLY_ACK;
            end else begin
              bad = 1'b1;
            end
          end
          tcprx_pkg::ST_ESTAB: begin
            priority if (item.seg_flags[tcprx_pkg::FLAG_FIN]) begin
              nstate          = tcprx_pkg::ST_PEER_FIN;
              res.reply_kind  = tcprx_pkg::REPLY_ACK;
              res.wake_events = tcprx_pkg::WAKE_RECV;
            end else if (item.seg_flags[tcprx_pkg::FLAG_ACK]) begin
              nwin = win_ok ? item.peer_window : ctx.window_to_peer;
              if (item.payload_len != '0) begin
                res.deliver_len = item.payload_len;
                res.wake_events = win_wake | tcprx_pkg::WAKE_RECV;
              end else begin
                res.wake_events = win_wake;
              end
            end else begin
              bad = 1'b1;
            end
          end
          tcprx_pkg::ST_LAST_ACK: begin
            if (ack_match) begin
              res.remove_lookup = 1'b1;
              res.release_port  = 1'b1;
              nstate            = tcprx_pkg::ST_CLOSED;
            end else begin
              bad = 1'b1;
            end
          end
          tcprx_pkg::ST_FIN_WAIT1: begin
            if (ack_match) begin
              nstate = tcprx_pkg::ST_FIN_WAIT2;
            end else begin
              bad = 1'b1;
            end
          end
          tcprx_pkg::ST_FIN_WAIT2: begin
            if ((item.seg_ack == item.send_next) &&
                (item.seg_flags[tcprx_pkg::FLAG_FIN] || item.seg_flags[tcprx_pkg::FLAG_ACK])) begin
              nstate             = tcprx_pkg::ST_LINGER;
              res.start_timewait = 1'b1;
              res.reply_kind     = tcprx_pkg::REPLY_ACK;
            end else begin
              bad = 1'b1;
            end
          end
          // closed, peer fin seen, closing, linger and unused codes
          default: begin
            bad = 1'b1;
          end
        endcase

        if (bad) begin
          res.reply_kind = tcprx_pkg::REPLY_RESET;
          nstate         = tcprx_pkg::ST_CLOSED;
        end
      end
    end

    res.dropped        = drop;
    res.next_state     = nstate;
    res.send_window    = nwin;
    upd.conn_state     = nstate;
    upd.window_to_peer = nwin;
  end

endmodule

[rtl/core/tcp_receive_state_machine.sv]
`timescale 1ns / 1ps
// Each beat passes through the input register and then the result register;
// the input register holds its beat while the result register is full and stalled.
// Throughput: one beat per cycle while out_stall is low; the state update is
// combinational between the input register and the result register.
// Reset (rst_n low, synchronous): both channels empty, connection closed,
// recorded sequence numbers and send window zero.

module tcp_receive_state_machine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tcprx_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcprx_pkg::out_beat_t out_data
);

  logic                 in_valid_r;
  tcprx_pkg::in_beat_t  in_r;
  logic [31:0]          rcv_end_r;
  logic [31:0]          rcv_end_nxt;
  logic                 out_valid_r;
  tcprx_pkg::out_beat_t out_r;

  logic [3:0]           conn_state_r;
  logic [31:0]          oldest_unacked_r;
  logic [31:0]          expect_next_r;
  logic [15:0]          window_to_peer_r;

  logic                 in_acc;
  logic                 adv;
  tcprx_pkg::ctx_t      ctx;
  tcprx_pkg::out_beat_t res;
  tcprx_pkg::upd_t      upd;

  // Handshake: the input register moves on when the result slot is free or drains
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // Right edge of the receive window, taken at accept: seq_end + max(window, 1)
  assign rcv_end_nxt = in_data.seg_seq_end +
                       {16'd0, ((in_data.local_window > 16'd1) ? in_data.local_window : 16'd1)};

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r      <= in_data;
      rcv_end_r <= rcv_end_nxt;
    end
  end

  assign ctx.conn_state     = conn_state_r;
  assign ctx.window_to_peer = window_to_peer_r;

  tcprx_step u_step (
    .item    (in_r),
    .rcv_end (rcv_end_r),
    .ctx     (ctx),
    .res     (res),
    .upd     (upd)
  );

  // Connection context, updated as a beat moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_state_r     <= tcprx_pkg::ST_CLOSED;
      oldest_unacked_r <= '0;
      expect_next_r    <= '0;
      window_to_peer_r <= '0;
    end else if (adv) begin
      conn_state_r     <= upd.conn_state;
      window_to_peer_r <= upd.window_to_peer;
      if (upd.load_seq) begin
        oldest_unacked_r <= in_r.seg_ack;
        expect_next_r    <= in_r.seg_seq_end;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A held input beat is never lost
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> in_valid_r)
    else $error("input beat lost while stalled");

  // Every advance produces a result beat
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advance without result beat");

  // Stored state never leaves the defined codes
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    conn_state_r <= tcprx_pkg::ST_LINGER)
    else $error("connection state out of range");

  // Dropped segments carry no reply and no delivery
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.dropped) |->
      (out_r.reply_kind == tcprx_pkg::REPLY_NONE && out_r.deliver_len == '0))
    else $error("dropped segment produced reply or data");

  // Child sequence is only reported with a spawn
  a_child: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.spawn_child) |-> (out_r.child_expect == '0))
    else $error("child_expect set without spawn");

endmodule
